### rtl/gsm7_pkg.sv
// ----------------------------------------------------------------------------
// gsm7_pkg
// Shared constants, types and lookup functions for the GSM 7-bit decoder.
// ----------------------------------------------------------------------------
package gsm7_pkg;

  localparam int unsigned CodeWidth = 8;
  localparam int unsigned CharWidth = 16;

  localparam logic [CodeWidth-1:0] CODE_ESC = 8'h1B;
  localparam logic [CodeWidth-1:0] CODE_END = 8'hFF;

  typedef struct packed {
    logic                 valid;
    logic [CharWidth-1:0] char;
  } result_t;

  // Default alphabet, codes 0x00..0x7F. Codes that are not listed map to
  // themselves.
  function automatic logic [CharWidth-1:0] base_lookup(input logic [6:0] c);
    logic [CharWidth-1:0] u;
    u = {9'h000, c};
    unique case (c)
      7'h00: u = 16'h0040;
      7'h01: u = 16'h00A3;
      7'h02: u = 16'h0024;
      7'h03: u = 16'h00A5;
      7'h04: u = 16'h00E8;
      7'h05: u = 16'h00E9;
      7'h06: u = 16'h00F9;
      7'h07: u = 16'h00EC;
      7'h08: u = 16'h00F2;
      7'h09: u = 16'h00C7;
      7'h0A: u = 16'h000A;
      7'h0B: u = 16'h00D8;
      7'h0C: u = 16'h00F8;
      7'h0D: u = 16'h000D;
      7'h0E: u = 16'h00C5;
      7'h0F: u = 16'h00E5;
      7'h10: u = 16'h0394;
      7'h11: u = 16'h005F;
      7'h12: u = 16'h03A6;
      7'h13: u = 16'h0393;
      7'h14: u = 16'h039B;
      7'h15: u = 16'h03A9;
      7'h16: u = 16'h03A0;
      7'h17: u = 16'h03A8;
      7'h18: u = 16'h03A3;
      7'h19: u = 16'h0398;
      7'h1A: u = 16'h039E;
      7'h1B: u = 16'h0020;
      7'h1C: u = 16'h00C6;
      7'h1D: u = 16'h00E6;
      7'h1E: u = 16'h00DF;
      7'h1F: u = 16'h00C9;
      7'h24: u = 16'h00A4;
      7'h40: u = 16'h00A1;
      7'h5B: u = 16'h00C4;
      7'h5C: u = 16'h00D6;
      7'h5D: u = 16'h00D1;
      7'h5E: u = 16'h00DC;
      7'h5F: u = 16'h00A7;
      7'h60: u = 16'h00BF;
      7'h7B: u = 16'h00E4;
      7'h7C: u = 16'h00F6;
      7'h7D: u = 16'h00F1;
      7'h7E: u = 16'h00FC;
      7'h7F: u = 16'h00E0;
      default: u = {9'h000, c};
    endcase
    return u;
  endfunction

  // Extension table, the code after an escape. valid low: no entry.
  function automatic result_t ext_lookup(input logic [CodeWidth-1:0] c);
    result_t r;
    r.valid = 1'b1;
    r.char  = 16'h0000;
    unique case (c)
      8'h0A: r.char = 16'h000C;
      8'h14: r.char = 16'h005E;
      8'h28: r.char = 16'h007B;
      8'h29: r.char = 16'h007D;
      8'h2F: r.char = 16'h005C;
      8'h3C: r.char = 16'h005B;
      8'h3D: r.char = 16'h007E;
      8'h3E: r.char = 16'h005D;
      8'h40: r.char = 16'h007C;
      8'h65: r.char = 16'h20AC;
      8'h1B: r.char = 16'h0020;
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### rtl/gsm7_decode.sv
// ----------------------------------------------------------------------------
// gsm7_decode
// Table decode of one code plus the escape and end-of-message state.
// ----------------------------------------------------------------------------
module gsm7_decode (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           advance_i,
  input  logic [gsm7_pkg::CodeWidth-1:0] code_i,
  input  logic                           start_of_message_i,
  output gsm7_pkg::result_t              result_o
);

  logic escape_q, escape_d;
  logic ended_q, ended_d;
  logic esc_cur, end_cur;
  gsm7_pkg::result_t ext;

  assign ext = gsm7_pkg::ext_lookup(code_i);

  always_comb begin
    // start of message clears both flags before the byte is decoded
    esc_cur       = escape_q & ~start_of_message_i;
    end_cur       = ended_q & ~start_of_message_i;
    escape_d      = esc_cur;
    ended_d       = end_cur;
    result_o      = '0;
    if (end_cur) begin
      result_o = '0;
    end else if (esc_cur) begin
      escape_d = 1'b0;
      result_o = ext;
    end else if (code_i == gsm7_pkg::CODE_ESC) begin
      escape_d = 1'b1;
    end else if (code_i == gsm7_pkg::CODE_END) begin
      ended_d = 1'b1;
    end else begin
      result_o.valid = 1'b1;
      result_o.char  = code_i[7] ? {8'h00, code_i}
                                 : gsm7_pkg::base_lookup(code_i[6:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q <= 1'b0;
      ended_q  <= 1'b0;
    end else if (advance_i) begin
      escape_q <= escape_d;
      ended_q  <= ended_d;
    end
  end

endmodule

### rtl/gsm7_out_reg.sv
// ----------------------------------------------------------------------------
// gsm7_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module gsm7_out_reg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  gsm7_pkg::result_t              result_i,
  output logic                           ready_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gsm7_pkg::CharWidth-1:0] unicode_char_o
);

  logic                           valid_q, valid_d;
  logic [gsm7_pkg::CharWidth-1:0] char_q, char_d;

  // can take a new result when empty or when the held one leaves now
  assign ready_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q & out_stall_i;
    char_d  = char_q;
    if (load_i && ready_o) begin
      valid_d = result_i.valid;
      char_d  = result_i.char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign out_valid_o    = valid_q;
  assign unicode_char_o = char_q;

endmodule

### rtl/gsm_7bit_to_unicode_decoder.sv
// ----------------------------------------------------------------------------
// gsm_7bit_to_unicode_decoder
// GSM 03.38 default alphabet (unpacked) to UCS-2 decoder with escape table.
// ----------------------------------------------------------------------------
// Result path: input reg, then result reg.
// One byte per cycle unless stalled; an output stall reaches in_stall_o combinationally.
// Bytes that decode to nothing (escape, end, after end, no ext entry) produce no result.
// Reset: asynchronous, active low; clears valids, escape and end-of-message.
module gsm_7bit_to_unicode_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [gsm7_pkg::CodeWidth-1:0] code_i,
  input  logic                           start_of_message_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gsm7_pkg::CharWidth-1:0] unicode_char_o
);

  logic                           in_vld_q;
  logic [gsm7_pkg::CodeWidth-1:0] code_q;
  logic                           som_q;
  logic                           out_ready;
  logic                           advance;
  gsm7_pkg::result_t              result;

  assign advance    = in_vld_q & out_ready;
  assign in_stall_o = in_vld_q & ~out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      code_q <= code_i;
      som_q  <= start_of_message_i;
    end
  end

  gsm7_decode u_decode (
    .clk_i,
    .rst_ni,
    .advance_i          (advance),
    .code_i             (code_q),
    .start_of_message_i (som_q),
    .result_o           (result)
  );

  gsm7_out_reg u_out_reg (
    .clk_i,
    .rst_ni,
    .load_i         (advance),
    .result_i       (result),
    .ready_o        (out_ready),
    .out_valid_o,
    .out_stall_i,
    .unicode_char_o
  );

endmodule

### rtl/gsm7_checker.sv
// ----------------------------------------------------------------------------
// gsm7_checker
// Port-level checks for the GSM 7-bit decoder, bound to the top level.
// ----------------------------------------------------------------------------
module gsm7_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [gsm7_pkg::CharWidth-1:0] unicode_char_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(unicode_char_o))
    else $error("stalled result changed");

  // input never stalls while the output side is free
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with free output");

  // every result lies in Latin-1, Greek, or is the euro sign
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (unicode_char_o[15:8] == 8'h00) ||
                    (unicode_char_o[15:8] == 8'h03) ||
                    (unicode_char_o == 16'h20AC))
    else $error("result outside decoder alphabet");

  // no result right after reset release without input
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind gsm_7bit_to_unicode_decoder gsm7_checker u_gsm7_checker (
  .clk_i,
  .rst_ni,
  .in_stall_o,
  .out_valid_o,
  .out_stall_i,
  .unicode_char_o
);

### sim/tb_gsm_7bit_to_unicode_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gsm_7bit_to_unicode_decoder
// Self-checking bench for the GSM 7-bit to UCS-2 decoder: a directed pass over
// table edges, escapes and end-of-text, then random messages with escape
// pairs, truncated escapes and trailing bytes, compared in order against a
// local decoder under random idle and stall on both channels.
// ----------------------------------------------------------------------------
module tb_gsm_7bit_to_unicode_decoder;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned IdlePct    = 17;

  // Default alphabet, codes 0x00..0x7F
  localparam logic [gsm7_pkg::CharWidth-1:0] BASIC_CHARSET [128] = '{
    16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
    16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
    16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
    16'h03A3, 16'h0398, 16'h039E, 16'h0020, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
    16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
    16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
    16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
    16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
    16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
    16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
  };

  // Codes that have an entry in the extension table
  localparam logic [gsm7_pkg::CodeWidth-1:0] EXT_CODES [11] = '{
    8'h0A, 8'h14, 8'h28, 8'h29, 8'h2F, 8'h3C, 8'h3D, 8'h3E, 8'h40, 8'h65,
    gsm7_pkg::CODE_ESC
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [gsm7_pkg::CodeWidth-1:0] code_i;
  logic                           start_of_message_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [gsm7_pkg::CharWidth-1:0] unicode_char_o;

  logic [gsm7_pkg::CharWidth-1:0] decoded_chars[$];
  bit                             esc_armed;
  bit                             text_ended;
  bit                             gaps_on;
  int unsigned                    n_bytes;
  int unsigned                    n_chars;
  int unsigned                    n_escapes;
  int unsigned                    n_ends;
  int unsigned                    n_errors;
  int unsigned                    cycles;

  gsm_7bit_to_unicode_decoder DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .code_i             (code_i),
    .start_of_message_i (start_of_message_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .unicode_char_o     (unicode_char_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit ext_char(input logic [gsm7_pkg::CodeWidth-1:0] c,
                                  output logic [gsm7_pkg::CharWidth-1:0] u);
    u = '0;
    case (c)
      8'h0A:              u = 16'h000C;
      8'h14:              u = 16'h005E;
      8'h28:              u = 16'h007B;
      8'h29:              u = 16'h007D;
      8'h2F:              u = 16'h005C;
      8'h3C:              u = 16'h005B;
      8'h3D:              u = 16'h007E;
      8'h3E:              u = 16'h005D;
      8'h40:              u = 16'h007C;
      8'h65:              u = 16'h20AC;
      gsm7_pkg::CODE_ESC: u = 16'h0020;
      default:            return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Advance the local decoder by one accepted byte; queue the char it yields.
  function automatic void decode_byte(input logic [gsm7_pkg::CodeWidth-1:0] c,
                                      input logic som);
    logic [gsm7_pkg::CharWidth-1:0] u;
    if (som) begin
      esc_armed  = 1'b0;
      text_ended = 1'b0;
    end
    if (text_ended) return;
    if (esc_armed) begin
      esc_armed = 1'b0;
      if (ext_char(c, u)) decoded_chars.push_back(u);
    end else if (c == gsm7_pkg::CODE_ESC) begin
      esc_armed = 1'b1;
      n_escapes++;
    end else if (c == gsm7_pkg::CODE_END) begin
      text_ended = 1'b1;
      n_ends++;
    end else if (c[7]) begin
      decoded_chars.push_back({8'h00, c});
    end else begin
      decoded_chars.push_back(BASIC_CHARSET[c[6:0]]);
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [gsm7_pkg::CodeWidth-1:0] c, input logic som);
    if (gaps_on) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i         <= 1'b1;
    code_i             <= c;
    start_of_message_i <= som;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(c, som);
    n_bytes++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (decoded_chars.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h27, 1'b0);     // apostrophe
    send_byte(8'h24, 1'b0);
    send_byte(8'h80, 1'b0);     // upper codes pass through
    send_byte(8'hFE, 1'b0);
    send_byte(gsm7_pkg::CODE_ESC, 1'b0);
    send_byte(8'h65, 1'b0);     // euro
    send_byte(gsm7_pkg::CODE_ESC, 1'b0);
    send_byte(gsm7_pkg::CODE_ESC, 1'b0);  // double escape is a space
    send_byte(gsm7_pkg::CODE_ESC, 1'b0);
    send_byte(8'h41, 1'b0);     // no extension entry: dropped
    send_byte(gsm7_pkg::CODE_ESC, 1'b0);
    send_byte(gsm7_pkg::CODE_END, 1'b0);  // end code under escape does not end the text
    send_byte(8'h30, 1'b0);
    send_byte(gsm7_pkg::CODE_ESC, 1'b0);
    send_byte(8'h41, 1'b1);     // new message drops the pending escape
    send_byte(gsm7_pkg::CODE_END, 1'b0);
    send_byte(8'h42, 1'b0);     // ignored after end
    send_byte(gsm7_pkg::CODE_ESC, 1'b0);
    send_byte(8'h65, 1'b0);
    send_byte(8'h10, 1'b1);
    send_byte(gsm7_pkg::CODE_ESC, 1'b0);
    send_byte(8'h0A, 1'b0);
  endtask

  task automatic test_random_messages(input int unsigned n_items);
    int unsigned                    sent;
    int unsigned                    len;
    int unsigned                    pick;
    int unsigned                    trail;
    logic [gsm7_pkg::CodeWidth-1:0] c;
    logic                           som;
    bit                             cut;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(24, 1);
      cut = 1'b0;
      for (int unsigned k = 0; k < len && !cut; k++) begin
        som  = (k == 0) ? 1'b1 : ($urandom_range(99) < 2);
        pick = $urandom_range(99);
        if (pick < 55) begin
          do c = 8'($urandom_range(127)); while (c == gsm7_pkg::CODE_ESC);
          send_byte(c, som);
          sent++;
        end else if (pick < 72) begin
          send_byte(gsm7_pkg::CODE_ESC, som);
          send_byte(EXT_CODES[$urandom_range(10)], 1'b0);
          sent += 2;
        end else if (pick < 77) begin
          send_byte(gsm7_pkg::CODE_ESC, som);
          send_byte(8'($urandom_range(255)), 1'b0);
          sent += 2;
        end else if (pick < 90) begin
          send_byte(8'($urandom_range(254, 128)), som);
          sent++;
        end else if (pick < 94) begin
          // escape as the last byte of the message
          send_byte(gsm7_pkg::CODE_ESC, som);
          sent++;
          cut = 1'b1;
        end else begin
          send_byte(gsm7_pkg::CODE_END, som);
          sent++;
          trail = $urandom_range(3);
          for (int unsigned t = 0; t < trail; t++) begin
            send_byte(8'($urandom_range(255)), 1'b0);
          end
          cut = 1'b1;
        end
      end
    end
  endtask

  task automatic test_drain_pause();
    test_random_messages(40);
    wait_drained();
    test_random_messages(40);
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    test_random_messages(250);
    gaps_on = 1'b1;
  endtask

  // Receiver side stall
  always @(negedge clk_i) begin
    out_stall_i <= gaps_on ? ($urandom_range(99) < IdlePct) : 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_chars++;
      if (decoded_chars.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports)
          $display("unexpected char 0x%04h at cycle %0d", unicode_char_o, cycles);
      end else begin
        if (unicode_char_o !== decoded_chars[0]) begin
          n_errors++;
          if (n_errors <= MaxReports)
            $display("char mismatch at cycle %0d: expected 0x%04h, got 0x%04h",
                     cycles, decoded_chars[0], unicode_char_o);
        end
        void'(decoded_chars.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d chars outstanding",
               cycles, decoded_chars.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    code_i             = '0;
    start_of_message_i = 1'b0;
    out_stall_i        = 1'b0;
    esc_armed          = 1'b0;
    text_ended         = 1'b0;
    gaps_on            = 1'b1;
    n_bytes            = 0;
    n_chars            = 0;
    n_escapes          = 0;
    n_ends             = 0;
    n_errors           = 0;
    cycles             = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_drain_pause();
    test_random_messages(500);
    test_back_to_back();
    test_random_messages(280);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (decoded_chars.size() != 0) begin
      n_errors += decoded_chars.size();
      $display("%0d chars never came out", decoded_chars.size());
    end
    $display("Sent %0d bytes (%0d escapes, %0d end-of-text codes), checked %0d chars,",
             n_bytes, n_escapes, n_ends, n_chars);
    $display("with random idle and stall on both sides plus one no-idle stretch.");
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/gsm7_pkg.sv
rtl/gsm7_decode.sv
rtl/gsm7_out_reg.sv
rtl/gsm_7bit_to_unicode_decoder.sv
rtl/gsm7_checker.sv
sim/tb_gsm_7bit_to_unicode_decoder.sv
